@@ design/mesi_l1_line_controller_core_macros.svh @@
// ----------------------------------------------------------------------------
// mesi_l1_line_controller_core_macros.svh
// assertion macros shared by the line controller rtl
// ----------------------------------------------------------------------------
`ifndef MESI_L1_LINE_CONTROLLER_CORE_MACROS_SVH
`define MESI_L1_LINE_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define MESIL1_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define MESIL1_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/mesil1_pkg.sv @@
// ----------------------------------------------------------------------------
// mesil1_pkg
// message codes, core request codes and mesi line states
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mesil1_pkg;

	// message codes, narrowed to the configured message width where used
	localparam logic [7:0] MSG_EMPTY         = 8'd0;
	localparam logic [7:0] MSG_STORE_REQ     = 8'd2;
	localparam logic [7:0] MSG_WB_REQ        = 8'd12;
	localparam logic [7:0] MSG_LOAD_FWD      = 8'd16;
	localparam logic [7:0] MSG_STORE_FWD     = 8'd17;
	localparam logic [7:0] MSG_INV_FWD       = 8'd18;
	localparam logic [7:0] MSG_LOAD_FWDACK   = 8'd21;
	localparam logic [7:0] MSG_STORE_FWDACK  = 8'd22;
	localparam logic [7:0] MSG_INV_FWDACK    = 8'd23;
	localparam logic [7:0] MSG_NODATA_ACK    = 8'd28;
	localparam logic [7:0] MSG_DATA_ACK      = 8'd29;
	localparam logic [7:0] MSG_LOAD_REQ      = 8'd31;

	// encoding matches the granted state field
	typedef enum logic [1:0] {
		ST_I = 2'd0,
		ST_S = 2'd1,
		ST_E = 2'd2,
		ST_M = 2'd3
	} mesi_t;

	typedef enum logic [1:0] {
		OP_READ      = 2'd0,
		OP_WRITE     = 2'd1,
		OP_WRITEBACK = 2'd2,
		OP_NONE      = 2'd3
	} core_op_t;

endpackage

@@ design/mesil1_ifs.sv @@
// ----------------------------------------------------------------------------
// mesil1 channel interfaces
// valid/ready channels for the step word and the result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mesil1_step_if #(
	parameter int DATA_BITS = 64,
	parameter int TAG_BITS  = 26,
	parameter int MSG_BITS  = 8
);
	logic                 valid;
	logic                 ready;
	logic [MSG_BITS-1:0]  l2_msg_type;
	logic [DATA_BITS-1:0] l2_msg_data;
	logic [TAG_BITS-1:0]  l2_msg_tag;
	logic [1:0]           granted_state;
	logic [1:0]           op;
	logic [TAG_BITS-1:0]  core_addr_tag;
	logic [DATA_BITS-1:0] core_write_data;

	modport source (
		output valid, l2_msg_type, l2_msg_data, l2_msg_tag, granted_state,
			op, core_addr_tag, core_write_data,
		input  ready
	);
	modport sink (
		input  valid, l2_msg_type, l2_msg_data, l2_msg_tag, granted_state,
			op, core_addr_tag, core_write_data,
		output ready
	);
endinterface

interface mesil1_result_if #(
	parameter int DATA_BITS = 64,
	parameter int TAG_BITS  = 26,
	parameter int MSG_BITS  = 8
);
	logic                 valid;
	logic                 ready;
	logic [MSG_BITS-1:0]  req_type;
	logic [TAG_BITS-1:0]  req_tag;
	logic [DATA_BITS-1:0] req_data;
	logic [MSG_BITS-1:0]  resp_type;
	logic [DATA_BITS-1:0] resp_data;

	modport source (
		output valid, req_type, req_tag, req_data, resp_type, resp_data,
		input  ready
	);
	modport sink (
		input  valid, req_type, req_tag, req_data, resp_type, resp_data,
		output ready
	);
endinterface

@@ design/mesi_l1_line_controller_core.sv @@
// ----------------------------------------------------------------------------
// mesi_l1_line_controller_core
// single-line l1 mesi controller: l2 messages and core requests in, channels out
// result path: an accepted step word passes the input reg, then the line regs
// throughput: 1 word per cycle while the result is not stalled; the line and channel regs update in one pass
// a stalled result holds the line regs and backs up into the input register
// reset: line invalid, both outgoing channels empty and zero; tag/data unset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "mesi_l1_line_controller_core_macros.svh"

module mesi_l1_line_controller_core #(
	parameter int DATA_BITS = 64,
	parameter int TAG_BITS  = 26,
	parameter int MSG_BITS  = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	mesil1_step_if.sink   step,
	mesil1_result_if.source result
);
	import mesil1_pkg::*;

	localparam logic [MSG_BITS-1:0] T_EMPTY        = MSG_BITS'(MSG_EMPTY);
	localparam logic [MSG_BITS-1:0] T_STORE_REQ    = MSG_BITS'(MSG_STORE_REQ);
	localparam logic [MSG_BITS-1:0] T_WB_REQ       = MSG_BITS'(MSG_WB_REQ);
	localparam logic [MSG_BITS-1:0] T_LOAD_FWD     = MSG_BITS'(MSG_LOAD_FWD);
	localparam logic [MSG_BITS-1:0] T_STORE_FWD    = MSG_BITS'(MSG_STORE_FWD);
	localparam logic [MSG_BITS-1:0] T_INV_FWD      = MSG_BITS'(MSG_INV_FWD);
	localparam logic [MSG_BITS-1:0] T_LOAD_FWDACK  = MSG_BITS'(MSG_LOAD_FWDACK);
	localparam logic [MSG_BITS-1:0] T_STORE_FWDACK = MSG_BITS'(MSG_STORE_FWDACK);
	localparam logic [MSG_BITS-1:0] T_INV_FWDACK   = MSG_BITS'(MSG_INV_FWDACK);
	localparam logic [MSG_BITS-1:0] T_NODATA_ACK   = MSG_BITS'(MSG_NODATA_ACK);
	localparam logic [MSG_BITS-1:0] T_DATA_ACK     = MSG_BITS'(MSG_DATA_ACK);
	localparam logic [MSG_BITS-1:0] T_LOAD_REQ     = MSG_BITS'(MSG_LOAD_REQ);

	// input register
	logic                 valid_s1;
	logic [MSG_BITS-1:0]  msg_type_s1;
	logic [DATA_BITS-1:0] msg_data_s1;
	logic [TAG_BITS-1:0]  msg_tag_s1;
	logic [1:0]           granted_s1;
	logic [1:0]           op_s1;
	logic [TAG_BITS-1:0]  addr_tag_s1;
	logic [DATA_BITS-1:0] wdata_s1;

	// line and channel registers; the channel regs are the result word
	mesi_t                line_state_q;
	logic [TAG_BITS-1:0]  line_tag_q;
	logic [DATA_BITS-1:0] line_data_q;
	logic [MSG_BITS-1:0]  req_type_q;
	logic [TAG_BITS-1:0]  req_tag_q;
	logic [DATA_BITS-1:0] req_data_q;
	logic [MSG_BITS-1:0]  resp_type_q;
	logic [DATA_BITS-1:0] resp_data_q;
	logic                 out_valid_q;

	mesi_t                line_state_d;
	logic [TAG_BITS-1:0]  line_tag_d;
	logic [DATA_BITS-1:0] line_data_d;
	logic [MSG_BITS-1:0]  req_type_d;
	logic [TAG_BITS-1:0]  req_tag_d;
	logic [DATA_BITS-1:0] req_data_d;
	logic [MSG_BITS-1:0]  resp_type_d;
	logic [DATA_BITS-1:0] resp_data_d;

	logic advance;
	logic hit;
	logic core_ok;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign step.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (step.ready) begin
			valid_s1 <= step.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step.valid && step.ready) begin
			msg_type_s1 <= step.l2_msg_type;
			msg_data_s1 <= step.l2_msg_data;
			msg_tag_s1  <= step.l2_msg_tag;
			granted_s1  <= step.granted_state;
			op_s1       <= step.op;
			addr_tag_s1 <= step.core_addr_tag;
			wdata_s1    <= step.core_write_data;
		end
	end

	assign hit     = (addr_tag_s1 == line_tag_q);
	assign core_ok = (msg_type_s1 == T_EMPTY) && (req_type_q == T_EMPTY);

	always_comb begin
		line_state_d = line_state_q;
		line_tag_d   = line_tag_q;
		line_data_d  = line_data_q;
		req_type_d   = req_type_q;
		req_tag_d    = req_tag_q;
		req_data_d   = req_data_q;
		resp_type_d  = resp_type_q;
		resp_data_d  = resp_data_q;

		priority if (msg_type_s1 == T_LOAD_FWD) begin
			if (line_state_q != ST_I) begin
				line_state_d = ST_S;
			end
			resp_data_d = line_data_q;
			resp_type_d = T_LOAD_FWDACK;
		end else if (msg_type_s1 == T_STORE_FWD) begin
			line_state_d = ST_I;
			resp_data_d  = line_data_q;
			resp_type_d  = T_STORE_FWDACK;
		end else if (msg_type_s1 == T_INV_FWD) begin
			line_state_d = ST_I;
			resp_type_d  = T_INV_FWDACK;
		end else if (msg_type_s1 == T_DATA_ACK) begin
			req_type_d   = T_EMPTY;
			resp_type_d  = T_EMPTY;
			line_data_d  = msg_data_s1;
			line_tag_d   = msg_tag_s1;
			line_state_d = mesi_t'(granted_s1);
		end else if (msg_type_s1 == T_NODATA_ACK) begin
			resp_type_d = T_EMPTY;
		end else if (core_ok && op_s1 == OP_READ) begin
			if (line_state_q == ST_I || !hit) begin
				req_type_d = T_LOAD_REQ;
			end
			req_tag_d = addr_tag_s1;
			// dirty victim goes out as a writeback
			if (!hit && line_state_q == ST_M) begin
				resp_type_d  = T_WB_REQ;
				resp_data_d  = line_data_q;
				line_state_d = ST_I;
			end
		end else if (core_ok && op_s1 == OP_WRITE) begin
			if (line_state_q == ST_I || line_state_q == ST_S || !hit) begin
				req_type_d = T_STORE_REQ;
			end
			req_tag_d  = addr_tag_s1;
			req_data_d = wdata_s1;
			if (hit && (line_state_q == ST_E || line_state_q == ST_M)) begin
				line_data_d  = wdata_s1;
				line_state_d = ST_M;
			end
			if (!hit && line_state_q == ST_M) begin
				resp_type_d  = T_WB_REQ;
				resp_data_d  = line_data_q;
				line_state_d = ST_I;
			end
		end else begin
			// unknown message, blocked or idle core request: no change
			line_state_d = line_state_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_state_q <= ST_I;
			req_type_q   <= T_EMPTY;
			req_tag_q    <= '0;
			req_data_q   <= '0;
			resp_type_q  <= T_EMPTY;
			resp_data_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				line_state_q <= line_state_d;
				req_type_q   <= req_type_d;
				req_tag_q    <= req_tag_d;
				req_data_q   <= req_data_d;
				resp_type_q  <= resp_type_d;
				resp_data_q  <= resp_data_d;
				out_valid_q  <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// tag and data have no reset value
	always_ff @(posedge clk) begin
		if (advance) begin
			line_tag_q  <= line_tag_d;
			line_data_q <= line_data_d;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.req_type  = req_type_q;
	assign result.req_tag   = req_tag_q;
	assign result.req_data  = req_data_q;
	assign result.resp_type = resp_type_q;
	assign result.resp_data = resp_data_q;

	`MESIL1_ASSERT_NEXT(a_data_ack_clears, clk, arst_n, advance && msg_type_s1 == T_DATA_ACK, req_type_q == T_EMPTY && resp_type_q == T_EMPTY, "data ack did not clear both channels")
	`MESIL1_ASSERT_NEXT(a_stall_holds_line, clk, arst_n, out_valid_q && !result.ready, $stable(line_state_q) && $stable(req_type_q) && $stable(resp_type_q), "line state moved while result stalled")
	`MESIL1_ASSERT_NEXT(a_write_hit_dirty, clk, arst_n, advance && core_ok && op_s1 == OP_WRITE && hit && (line_state_q == ST_E || line_state_q == ST_M), line_state_q == ST_M && line_data_q == $past(wdata_s1), "write hit on owned line not applied")
	`MESIL1_ASSERT_NOW(a_step_needs_slot, clk, arst_n, valid_s1 && out_valid_q && !result.ready, !step.ready, "step accepted with no room")

endmodule
